### hdl/rssc_pkg.sv
// Package: shared widths, queue entry type and GF(2^m) helpers of the syndrome calculator.
`timescale 1ns / 1ps

package rssc_pkg;

  localparam int SYMBOL_BITS   = 8;
  localparam int NUM_SYNDROMES = 16;

  localparam int SYM_W     = SYMBOL_BITS;
  localparam int POLY_W    = 13;
  localparam int LEN_W     = 12;
  localparam int IDX_OUT_W = 6;
  localparam int SYN_IDX_W = (NUM_SYNDROMES > 1) ? $clog2(NUM_SYNDROMES) : 1;

  localparam int Q_DEPTH  = 4;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = QPTR_W + 1;

  typedef logic [SYM_W-1:0] sym_t;

  // One queued work transaction for the accumulator bank.
  typedef struct packed {
    sym_t sym;
    logic load;  // first symbol of a codeword: load every accumulator
    logic done;  // codeword complete after this symbol: capture syndromes
  } op_t;

  function automatic sym_t gf_times_alpha(input sym_t x, input sym_t p);
    sym_t r;
    r = {x[SYM_W-2:0], 1'b0};
    if (x[SYM_W-1]) begin
      r = r ^ p;
    end
    return r;
  endfunction

  function automatic sym_t gf_mul(input sym_t a, input sym_t b, input sym_t p);
    sym_t r;
    r = '0;
    for (int k = SYM_W - 1; k >= 0; k--) begin
      r = gf_times_alpha(r, p);
      if (b[k]) begin
        r = r ^ a;
      end
    end
    return r;
  endfunction

endpackage

### hdl/rssc_front.sv
// Front end: accepts symbols, tracks the codeword position and classifies each transaction.
`timescale 1ns / 1ps

module rssc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  rssc_pkg::sym_t             symbol_i,
  input  logic                       first_i,
  input  logic [rssc_pkg::LEN_W-1:0] cw_len_i,
  input  logic                       q_full_i,
  output logic                       op_valid_o,
  output rssc_pkg::op_t              op_o
);
  import rssc_pkg::*;

  logic [LEN_W-1:0] count_q, count_d, count_n;
  logic             accept;
  logic             done;

  assign accept = push_i && !q_full_i;
  assign full_o = q_full_i;

  always_comb begin
    count_n    = count_q;
    op_valid_o = 1'b0;
    if (accept) begin
      if (first_i) begin
        count_n    = LEN_W'(1);
        op_valid_o = 1'b1;
      end else if (count_q != '0) begin
        count_n    = count_q + LEN_W'(1);
        op_valid_o = 1'b1;
      end
    end
    done    = op_valid_o && (count_n != '0) && (count_n == cw_len_i);
    count_d = done ? '0 : count_n;
  end

  assign op_o.sym  = symbol_i;
  assign op_o.load = first_i;
  assign op_o.done = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // An idle front only leaves idle on a first-flagged symbol.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) && !(accept && first_i) |=> (count_q == '0))
    else $error("symbol count left idle without a first symbol");

endmodule

### hdl/rssc_queue.sv
// Short work queue between the front end and the accumulator bank.
`timescale 1ns / 1ps

module rssc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  rssc_pkg::op_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output rssc_pkg::op_t rd_data_o,
  output logic          empty_o
);
  import rssc_pkg::*;

  op_t               mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == QCNT_W'(Q_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(Q_DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

### hdl/rssc_back.sv
// Back end: alpha power table, Horner accumulator lanes and syndrome output buffer.
`timescale 1ns / 1ps

module rssc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rssc_pkg::POLY_W-1:0]    poly_i,
  input  logic                           poly_wr_i,
  input  logic                           q_empty_i,
  input  rssc_pkg::op_t                  op_i,
  output logic                           q_pop_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic [rssc_pkg::IDX_OUT_W-1:0] syndrome_index_o,
  output rssc_pkg::sym_t                 syndrome_value_o,
  output logic                           last_o
);
  import rssc_pkg::*;

  localparam logic [SYN_IDX_W-1:0] LastIdx = SYN_IDX_W'(NUM_SYNDROMES - 1);

  sym_t                 pow_q  [NUM_SYNDROMES];
  sym_t                 acc_q  [NUM_SYNDROMES];
  sym_t                 snap_q [NUM_SYNDROMES];
  sym_t                 lane_new [NUM_SYNDROMES];
  sym_t                 poly_low;
  sym_t                 pow_wr;
  logic                 sweep_q;
  logic [SYN_IDX_W-1:0] sweep_idx_q;
  logic                 out_busy_q;
  logic [SYN_IDX_W-1:0] out_idx_q;
  logic                 out_free;
  logic                 capture;

  assign poly_low = poly_i[SYM_W-1:0];

  // Power table sweep: one entry per cycle after reset and after a polynomial write.
  assign pow_wr = (sweep_idx_q == '0) ? SYM_W'(1)
                : gf_times_alpha(pow_q[sweep_idx_q - SYN_IDX_W'(1)], poly_low);

  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      pow_q[sweep_idx_q] <= pow_wr;
    end
  end

  assign out_free = !out_busy_q || (pop_i && (out_idx_q == LastIdx));
  assign q_pop_o  = !q_empty_i && !sweep_q && (!op_i.done || out_free);
  assign capture  = q_pop_o && op_i.done;

  always_comb begin
    for (int i = 0; i < NUM_SYNDROMES; i++) begin
      lane_new[i] = op_i.load ? op_i.sym
                  : (op_i.sym ^ gf_mul(acc_q[i], pow_q[i], poly_low));
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      acc_q <= lane_new;
    end
    if (capture) begin
      snap_q <= lane_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_idx_q <= '0;
      out_busy_q  <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      if (poly_wr_i) begin
        sweep_q     <= 1'b1;
        sweep_idx_q <= '0;
      end else if (sweep_q) begin
        if (sweep_idx_q == LastIdx) begin
          sweep_q <= 1'b0;
        end
        sweep_idx_q <= sweep_idx_q + SYN_IDX_W'(1);
      end

      if (capture) begin
        out_busy_q <= 1'b1;
        out_idx_q  <= '0;
      end else if (pop_i && out_busy_q) begin
        if (out_idx_q == LastIdx) begin
          out_busy_q <= 1'b0;
        end
        out_idx_q <= out_idx_q + SYN_IDX_W'(1);
      end
    end
  end

  assign empty_o          = !out_busy_q;
  assign syndrome_index_o = IDX_OUT_W'(out_idx_q);
  assign syndrome_value_o = snap_q[out_idx_q];
  assign last_o           = (out_idx_q == LastIdx);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !q_pop_o)
    else $error("work dequeued while power table is rebuilt");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> (!empty_o && (out_idx_q == '0)))
    else $error("captured syndromes not presented from index zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |-> out_free)
    else $error("syndrome buffer overwritten before drained");

endmodule

### hdl/rs_syndrome_calculator_top.sv
// Top level: configuration registers and the front end, queue and back end of the calculator.
// Throughput: one symbol per clock unless full; syndromes drain one per pop, 16 per codeword.
// The first syndrome shows (empty low) once the last symbol is dequeued and captured.
// A new codeword's capture waits until the previous 16 syndromes drained; with pop held high and
//   codewords of 16+ symbols, only a rebuild stalls input; shorter ones back up a 4-entry queue.
// Reset: control state clears, registers return to prim_poly 285 and codeword_length 255, and
//   the 16 alpha powers are rebuilt (also after every prim_poly write) while symbols queue.
`timescale 1ns / 1ps

module rs_syndrome_calculator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // symbol input side
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     symbol_i,
  input  logic                           first_i,
  // syndrome output side
  output logic                           empty,
  input  logic                           pop,
  output logic [rssc_pkg::IDX_OUT_W-1:0] syndrome_index_o,
  output logic [7:0]                     syndrome_value_o,
  output logic                           last_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rssc_pkg::*;

  // Register map: one word per register, selected by address bit 2.
  localparam logic RegPrimPoly = 1'b0;
  localparam logic RegCwLen    = 1'b1;

  logic [POLY_W-1:0] poly_q;
  logic [LEN_W-1:0]  len_q;
  logic              cfg_wr;
  logic              poly_wr;

  // Front to queue, queue to back.
  op_t  fe_op, q_op;
  logic fe_valid;
  logic q_full, q_empty, q_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign poly_wr = cfg_wr && (paddr[2] == RegPrimPoly);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_W'(285);
      len_q  <= LEN_W'(255);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegPrimPoly: poly_q <= pwdata[POLY_W-1:0];
        RegCwLen:    len_q  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegPrimPoly: prdata = 32'(poly_q);
      RegCwLen:    prdata = 32'(len_q);
      default:     prdata = '0;
    endcase
  end

  // Classify each symbol transaction and track codeword position.
  rssc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .symbol_i   (symbol_i),
    .first_i    (first_i),
    .cw_len_i   (len_q),
    .q_full_i   (q_full),
    .op_valid_o (fe_valid),
    .op_o       (fe_op)
  );

  // Decouple symbol intake from the accumulator bank.
  rssc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fe_valid),
    .wr_data_i (fe_op),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .rd_data_o (q_op),
    .empty_o   (q_empty)
  );

  // Accumulate syndromes and drain them one per pop.
  rssc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .poly_i           (poly_q),
    .poly_wr_i        (poly_wr),
    .q_empty_i        (q_empty),
    .op_i             (q_op),
    .q_pop_o          (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .syndrome_index_o (syndrome_index_o),
    .syndrome_value_o (syndrome_value_o),
    .last_o           (last_o)
  );

endmodule

### bench/rs_syndrome_calculator_top_test.sv
// Testbench: Reed-Solomon syndrome calculator checked against its own GF(2^8) syndrome predictor.
`timescale 1ns / 1ps

module rs_syndrome_calculator_top_test;

  localparam int SYM_W   = rssc_pkg::SYM_W;
  localparam int NUM_SYN = rssc_pkg::NUM_SYNDROMES;
  localparam int POLY_W  = rssc_pkg::POLY_W;
  localparam int LEN_W   = rssc_pkg::LEN_W;
  localparam int IDX_W   = rssc_pkg::IDX_OUT_W;

  // Register map: prim_poly first, codeword_length second, 32-bit stride.
  localparam logic [2:0] POLY_ADDR   = 3'd0;
  localparam logic [2:0] LENGTH_ADDR = 3'd4;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  // Covers the path to the first syndrome, an alpha rebuild and a 4-deep queue,
  // rounded up generously.
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_EVERY    = 100;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 46;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    rssc_pkg::sym_t sym;
    logic           first;
  } symbol_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] syndrome_index;
    rssc_pkg::sym_t   syndrome_value;
    logic             last_flag;
  } syndrome_t;

  // DUT ports; the inputs are known from time zero.
  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 push    = 1'b0;
  logic                 full;
  logic [7:0]           symbol_i = '0;
  logic                 first_i  = 1'b0;
  logic                 empty;
  logic                 pop     = 1'b0;
  logic [IDX_W-1:0]     syndrome_index_o;
  logic [7:0]           syndrome_value_o;
  logic                 last_o;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [2:0]           paddr   = '0;
  logic [31:0]          pwdata  = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Predictor state: register copies, accumulators, symbol count and alpha powers.
  logic [POLY_W-1:0]    cfg_poly;
  logic [LEN_W-1:0]     cfg_len;
  rssc_pkg::sym_t       syn_acc   [NUM_SYN];
  rssc_pkg::sym_t       alpha_pow [NUM_SYN];
  logic [LEN_W-1:0]     sym_count;

  symbol_item_t         symbols_to_send[$];
  syndrome_t            expected_syndromes[$];

  bit                   no_gaps = 1'b0;
  int                   gap_left = 0;
  int                   wait_left = 0;
  int                   hold_left = 0;
  int                   syndromes_seen = 0;
  int                   error_count = 0;
  int                   cycle_count = 0;

  rs_syndrome_calculator_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .symbol_i         (symbol_i),
    .first_i          (first_i),
    .empty            (empty),
    .pop              (pop),
    .syndrome_index_o (syndrome_index_o),
    .syndrome_value_o (syndrome_value_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Syndrome predictor
  // ---------------------------------------------------------------------------

  // Multiply by alpha: shift up, fold the carried-out top bit back with the
  // low bits of the polynomial. Any polynomial is taken as it is.
  function automatic rssc_pkg::sym_t mul_by_alpha(input rssc_pkg::sym_t x);
    return {x[SYM_W-2:0], 1'b0} ^ ({SYM_W{x[SYM_W-1]}} & cfg_poly[SYM_W-1:0]);
  endfunction

  // Product a*b, scanning b from its low bit while stepping a through powers
  // of alpha; the alpha map is linear, so any polynomial gives the same sum.
  function automatic rssc_pkg::sym_t gf_product(input rssc_pkg::sym_t a,
                                                input rssc_pkg::sym_t b);
    rssc_pkg::sym_t acc;
    rssc_pkg::sym_t term;
    acc  = '0;
    term = a;
    for (int k = 0; k < SYM_W; k++) begin
      if (b[k]) begin
        acc = acc ^ term;
      end
      term = mul_by_alpha(term);
    end
    return acc;
  endfunction

  function automatic void rebuild_alpha_powers();
    rssc_pkg::sym_t p;
    p = SYM_W'(1);
    for (int i = 0; i < NUM_SYN; i++) begin
      alpha_pow[i] = p;
      p = mul_by_alpha(p);
    end
  endfunction

  function automatic void reset_predictor();
    cfg_poly  = 13'd285;
    cfg_len   = 12'd255;
    sym_count = '0;
    for (int i = 0; i < NUM_SYN; i++) begin
      syn_acc[i] = '0;
    end
    rebuild_alpha_powers();
  endfunction

  // Fold one accepted symbol into every accumulator; on the codeword's last
  // symbol, queue all syndromes in index order.
  function automatic void absorb_symbol(input rssc_pkg::sym_t sym, input logic first);
    syndrome_t s;
    if (first) begin
      for (int i = 0; i < NUM_SYN; i++) begin
        syn_acc[i] = sym;
      end
      sym_count = LEN_W'(1);
    end else if (sym_count == 0) begin
      // Idle: the symbol is dropped.
      return;
    end else begin
      for (int i = 0; i < NUM_SYN; i++) begin
        syn_acc[i] = sym ^ gf_product(syn_acc[i], alpha_pow[i]);
      end
      sym_count = sym_count + 1'b1;  // wraps from 4095 to zero
    end
    if (sym_count != 0 && sym_count == cfg_len) begin
      sym_count = '0;
      for (int i = 0; i < NUM_SYN; i++) begin
        s.syndrome_index = i[IDX_W-1:0];
        s.syndrome_value = syn_acc[i];
        s.last_flag      = (i == NUM_SYN - 1);
        expected_syndromes.push_back(s);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Symbol driver: present queued symbols, random gap before each next one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : send_symbols
    symbol_item_t next_item;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      // Predict on the transaction that this edge completes.
      if (push && !full) begin
        absorb_symbol(symbol_i, first_i);
      end
      // Hold the offered symbol while full, otherwise advance.
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (symbols_to_send.size() != 0) begin
          next_item = symbols_to_send.pop_front();
          symbol_i <= next_item.sym;
          first_i  <= next_item.first;
          push     <= 1'b1;
          gap_left = no_gaps ? 0 : $urandom_range(0, 3);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Syndrome monitor: compare each popped syndrome with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_syndromes
    syndrome_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_syndromes.size() == 0) begin
          $error("unexpected syndrome: index %0d value 0x%02h last %0b",
                 syndrome_index_o, syndrome_value_o, last_o);
          error_count++;
        end else begin
          want = expected_syndromes.pop_front();
          if (syndrome_index_o !== want.syndrome_index) begin
            $error("syndrome_index: expected %0d, actual %0d",
                   want.syndrome_index, syndrome_index_o);
            error_count++;
          end
          if (syndrome_value_o !== want.syndrome_value) begin
            $error("syndrome_value: expected 0x%02h, actual 0x%02h",
                   want.syndrome_value, syndrome_value_o);
            error_count++;
          end
          if (last_o !== want.last_flag) begin
            $error("last: expected %0b, actual %0b", want.last_flag, last_o);
            error_count++;
          end
        end
        syndromes_seen++;
        // Now and then drop pop for a long stretch so the block backs up
        // and has to stall the symbol side.
        if (syndromes_seen % HOLD_EVERY == 0 && syndromes_seen <= 2 * HOLD_EVERY) begin
          hold_left = LONG_HOLD;
        end else begin
          wait_left = no_gaps ? 0 : $urandom_range(0, 3);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rs_syndrome_calculator_top_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_symbol(input rssc_pkg::sym_t sym, input logic first);
    symbol_item_t item;
    item.sym   = sym;
    item.first = first;
    symbols_to_send.push_back(item);
  endfunction

  // Write one register over the APB-style port: setup, access, then wait
  // for pready on the access edge. Mirror the write in the predictor there.
  task automatic program_register(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (addr == POLY_ADDR) begin
      cfg_poly = data[POLY_W-1:0];
      rebuild_alpha_powers();
    end else begin
      cfg_len = data[LEN_W-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every symbol went in and every syndrome came out, then let
  // the block finish any trailing work that causes no syndrome.
  task automatic wait_until_drained();
    while (symbols_to_send.size() != 0 || push || expected_syndromes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly whole codewords of random content; some cut short by a restart,
  // some idle noise. Noise that the block drops is not counted.
  task automatic queue_codewords(input int item_budget);
    int  taken;
    int  cw_len;
    int  pick;
    int  cut;
    int  noise;
    bit  idle_state;
    taken      = 0;
    cw_len     = cfg_len;
    idle_state = 1'b0;
    while (taken < item_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        noise = $urandom_range(1, 3);
        repeat (noise) begin
          queue_symbol(SYM_W'($urandom_range(0, 255)), 1'b0);
          if (!idle_state) begin
            taken++;
          end
        end
      end else begin
        cut = (pick < 25) ? $urandom_range(0, cw_len - 2) : cw_len - 1;
        queue_symbol(SYM_W'($urandom_range(0, 255)), 1'b1);
        for (int k = 0; k < cut; k++) begin
          queue_symbol(SYM_W'($urandom_range(0, 255)), 1'b0);
        end
        taken += cut + 1;
        idle_state = (cut == cw_len - 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [31:0] word;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short codewords under the reset polynomial. An idle symbol is dropped,
    // a first flag mid-codeword restarts it.
    program_register(LENGTH_ADDR, 32'd4);
    queue_symbol(8'hFF, 1'b0);
    queue_symbol(8'h00, 1'b1);
    queue_symbol(8'hFF, 1'b0);
    queue_symbol(8'h80, 1'b0);
    queue_symbol(8'h01, 1'b0);
    queue_symbol(8'hAA, 1'b1);
    queue_symbol(8'h01, 1'b1);
    queue_symbol(8'h7F, 1'b0);
    queue_symbol(8'hFE, 1'b0);
    queue_symbol(8'hFF, 1'b0);
    wait_until_drained();

    // Length one: each first symbol completes a codeword on its own.
    program_register(LENGTH_ADDR, 32'd1);
    queue_symbol(8'hFF, 1'b1);
    queue_symbol(8'h00, 1'b1);
    queue_symbol(8'h5A, 1'b0);
    wait_until_drained();

    // Polynomial extremes: all zeros, then all ones with junk above bit 12.
    program_register(POLY_ADDR, 32'd0);
    program_register(LENGTH_ADDR, 32'd3);
    queue_symbol(8'h80, 1'b1);
    queue_symbol(8'hFF, 1'b0);
    queue_symbol(8'h81, 1'b0);
    wait_until_drained();
    program_register(POLY_ADDR, 32'hFFFF_FFFF);
    program_register(LENGTH_ADDR, 32'd2);
    queue_symbol(8'hFF, 1'b1);
    queue_symbol(8'h80, 1'b0);
    wait_until_drained();

    // Shrink the length below the running count: the codeword runs on with
    // no syndromes until a new first flag restarts it.
    program_register(POLY_ADDR, 32'hABCD_011D);
    program_register(LENGTH_ADDR, 32'd6);
    queue_symbol(8'h11, 1'b1);
    queue_symbol(8'h22, 1'b0);
    queue_symbol(8'h33, 1'b0);
    queue_symbol(8'h44, 1'b0);
    wait_until_drained();
    program_register(LENGTH_ADDR, 32'hFFFF_F003);
    queue_symbol(8'h55, 1'b0);
    queue_symbol(8'h66, 1'b0);
    queue_symbol(8'h77, 1'b1);
    queue_symbol(8'h88, 1'b0);
    queue_symbol(8'h99, 1'b0);
    wait_until_drained();

    // Random phases: polynomial (285 every fourth phase) and short length each time,
    // one longer length, every third phase with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_gaps = (p % 3 == 2);
      word = (p % 4 == 0) ? 32'd285 : $urandom;
      program_register(POLY_ADDR, word);
      word = $urandom & ~32'hFFF;
      word = word | ((p == 5) ? 32'd40 : $urandom_range(2, 24));
      program_register(LENGTH_ADDR, word);
      queue_codewords(PHASE_ITEMS);
      wait_until_drained();
    end
    no_gaps = 1'b0;

    // Length zero is never reached: the codeword runs on with no syndromes.
    // Raising the length above the count lets the same codeword complete,
    // after which a plain symbol is dropped.
    program_register(POLY_ADDR, $urandom);
    program_register(LENGTH_ADDR, 32'd0);
    queue_symbol(SYM_W'($urandom_range(0, 255)), 1'b1);
    repeat (8) queue_symbol(SYM_W'($urandom_range(0, 255)), 1'b0);
    wait_until_drained();
    program_register(LENGTH_ADDR, 32'd12);
    repeat (3) queue_symbol(SYM_W'($urandom_range(0, 255)), 1'b0);
    queue_symbol(8'hC3, 1'b0);
    wait_until_drained();

    if (error_count == 0) begin
      $display("rs_syndrome_calculator_top_test passed");
    end else begin
      $display("rs_syndrome_calculator_top_test failed");
    end
    $finish;
  end

endmodule
